// ===== rtl/csa_pkg.sv =====
package csa_pkg;

  localparam int BODY_COUNT = 1024;
  localparam int BODY_W     = $clog2(BODY_COUNT);
  localparam int STRESS_W   = 32;
  localparam int NUM_W      = 60;
  localparam int AREA_W     = 34;
  localparam int MUL_AW     = 40;
  localparam int MUL_BW     = 20;
  localparam int MUL_PW     = MUL_AW + MUL_BW;
  localparam logic [17:0] PI_Q16 = 18'd205887;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ACC   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [9:0]  body_a;
    logic [9:0]  body_b;
    logic [15:0] radius_a;
    logic [15:0] radius_b;
    logic [47:0] normal_vec;
    logic [59:0] normal_force_vec;
    logic [59:0] shear_force_vec;
  } in_t;

  typedef struct packed {
    logic signed [31:0] normal_stress_x;
    logic signed [31:0] normal_stress_y;
    logic signed [31:0] normal_stress_z;
    logic signed [31:0] shear_stress_x;
    logic signed [31:0] shear_stress_y;
    logic signed [31:0] shear_stress_z;
    logic [1:0]         status;
  } out_t;

  // saturating add of a quotient into a store entry, returns {clipped, value}
  function automatic logic [STRESS_W:0] sat_add(logic signed [STRESS_W-1:0] old_v,
                                                logic signed [NUM_W-1:0] q);
    logic signed [63:0] sum;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    logic [STRESS_W:0]  res;
    sum = 64'(old_v) + 64'(q);
    hi  = (64'sd1 <<< (STRESS_W - 1)) - 64'sd1;
    lo  = -hi - 64'sd1;
    if (sum > hi) begin
      res = {1'b1, hi[STRESS_W-1:0]};
    end else if (sum < lo) begin
      res = {1'b1, lo[STRESS_W-1:0]};
    end else begin
      res = {1'b0, sum[STRESS_W-1:0]};
    end
    return res;
  endfunction

  // clip a stored value to the 32-bit result range, returns {clipped, value}
  function automatic logic [32:0] clamp32(logic signed [STRESS_W-1:0] v);
    logic signed [63:0] w;
    logic [32:0]        res;
    w = 64'(v);
    if (w > 64'sh7fffffff) begin
      res = {1'b1, 32'h7fffffff};
    end else if (w < -64'sh80000000) begin
      res = {1'b1, 32'h80000000};
    end else begin
      res = {1'b0, w[31:0]};
    end
    return res;
  endfunction

endpackage

// ===== rtl/contact_stress_accumulator.sv =====
// Per-body contact stress store with 1024 entries of normal and shear stress
// (three Q16.16 components each). Operation 1 adds one contact's contribution
// to both bodies, operation 2 reads one body, operation 0 clears the store.
// One item is in work at a time. An accumulate runs 11 products on the shared
// multiplier, then six 60-bit divisions by the area on the one-bit-per-cycle
// divider, then two read-modify-writes of the store. A clear sweeps the store
// one entry per cycle, and the same sweep runs after reset, during which no
// transaction is accepted. A result waits in an output register, so the next
// transaction can be taken while the previous result is still stalled.
module contact_stress_accumulator (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  csa_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output csa_pkg::out_t  out_data
);

  localparam int SW = csa_pkg::STRESS_W;
  localparam int BW = csa_pkg::BODY_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RR, S_AREA, S_DOT, S_ND, S_SP, S_DIV, S_RMW, S_READ, S_OUT
  } state_t;

  state_t                              state_r;
  logic                                ph_r;
  logic [2:0]                          k_r;
  logic [BW-1:0]                       clr_addr_r;
  logic                                clr_rsp_r;
  csa_pkg::in_t                        item_r;
  logic [15:0]                         r_r;
  logic [31:0]                         rr_r;
  logic [csa_pkg::AREA_W-1:0]          area_r;
  logic signed [37:0]                  dot_r;
  logic signed [csa_pkg::NUM_W-1:0]    nd_r [3];
  logic signed [36:0]                  sp_r [3];
  logic signed [csa_pkg::NUM_W-1:0]    q_r  [6];
  logic                                sat_r;
  csa_pkg::out_t                       res_r;
  logic                                out_valid_r;
  csa_pkg::out_t                       out_data_r;

  // store
  logic [3*SW-1:0]  nmem [csa_pkg::BODY_COUNT];
  logic [3*SW-1:0]  smem [csa_pkg::BODY_COUNT];
  logic [3*SW-1:0]  nrd_r;
  logic [3*SW-1:0]  srd_r;
  logic [BW-1:0]    mem_addr;
  logic             mem_we;
  logic [3*SW-1:0]  wn;
  logic [3*SW-1:0]  ws;
  logic             rmw_sat;

  // arithmetic units
  logic signed [csa_pkg::MUL_AW-1:0]   ma;
  logic signed [csa_pkg::MUL_BW-1:0]   mb;
  logic signed [csa_pkg::MUL_PW-1:0]   prod;
  logic                                div_start;
  logic signed [csa_pkg::NUM_W-1:0]    div_num;
  logic                                div_done;
  logic signed [csa_pkg::NUM_W-1:0]    div_quo;

  logic signed [15:0] nv [3];
  logic signed [19:0] fv [3];
  logic signed [19:0] sv [3];
  logic [15:0]        r_pick;
  logic signed [37:0] sh_sum;
  logic [32:0]        rd_n [3];
  logic [32:0]        rd_s [3];

  csa_mul u_mul (
    .clk    (clk),
    .op_a   (ma),
    .op_b   (mb),
    .prod_r (prod)
  );

  csa_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (area_r),
    .done_r (div_done),
    .quo    (div_quo)
  );

  // unpack vector components
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nv[i] = item_r.normal_vec[16*i +: 16];
      fv[i] = item_r.normal_force_vec[20*i +: 20];
      sv[i] = item_r.shear_force_vec[20*i +: 20];
    end
  end

  // smaller nonzero radius
  always_comb begin
    if (in_data.radius_a == 16'd0) begin
      r_pick = in_data.radius_b;
    end else if (in_data.radius_b == 16'd0) begin
      r_pick = in_data.radius_a;
    end else if (in_data.radius_a < in_data.radius_b) begin
      r_pick = in_data.radius_a;
    end else begin
      r_pick = in_data.radius_b;
    end
  end

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_r)
      S_RR: begin
        ma = {24'd0, r_r};
        mb = {4'd0, r_r};
      end
      S_AREA: begin
        ma = {8'd0, rr_r};
        mb = {2'd0, csa_pkg::PI_Q16};
      end
      S_DOT: begin
        ma = 40'(nv[k_r[1:0]]);
        mb = fv[k_r[1:0]];
      end
      S_ND: begin
        ma = 40'(dot_r);
        mb = 20'(nv[k_r[1:0]]);
      end
      S_SP: begin
        ma = 40'(nv[k_r[1:0]]);
        mb = sv[k_r[1:0]];
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // divider numerator: normal terms stored, shear terms summed here
  always_comb begin
    unique case (k_r)
      3'd3:    sh_sum = 38'(sp_r[1]) + 38'(sp_r[2]);
      3'd4:    sh_sum = 38'(sp_r[2]) + 38'(sp_r[0]);
      3'd5:    sh_sum = 38'(sp_r[0]) + 38'(sp_r[1]);
      default: sh_sum = '0;
    endcase
    if (k_r < 3'd3) begin
      div_num = nd_r[k_r[1:0]];
    end else begin
      div_num = {{4{sh_sum[37]}}, sh_sum[37:0], 18'd0};
    end
  end

  assign div_start = (state_r == S_DIV) && !ph_r;

  // store port control and saturating update
  always_comb begin
    mem_we   = 1'b0;
    mem_addr = item_r.body_a;
    rmw_sat  = 1'b0;
    wn       = '0;
    ws       = '0;
    for (int i = 0; i < 3; i++) begin
      logic [SW:0] an;
      logic [SW:0] as;
      an = csa_pkg::sat_add(nrd_r[SW*i +: SW], q_r[i]);
      as = csa_pkg::sat_add(srd_r[SW*i +: SW], q_r[3+i]);
      wn[SW*i +: SW] = an[SW-1:0];
      ws[SW*i +: SW] = as[SW-1:0];
      rmw_sat = rmw_sat | an[SW] | as[SW];
      rd_n[i] = csa_pkg::clamp32(nrd_r[SW*i +: SW]);
      rd_s[i] = csa_pkg::clamp32(srd_r[SW*i +: SW]);
    end
    unique case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr_r;
        wn       = '0;
        ws       = '0;
      end
      S_RMW: begin
        mem_addr = k_r[0] ? item_r.body_b : item_r.body_a;
        mem_we   = ph_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      nmem[mem_addr] <= wn;
      smem[mem_addr] <= ws;
    end
    nrd_r <= nmem[mem_addr];
    srd_r <= smem[mem_addr];
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      clr_rsp_r   <= 1'b0;
      out_valid_r <= 1'b0;
      ph_r        <= 1'b0;
      k_r         <= '0;
    end else begin
      // output register drains unless a new result is loaded this cycle
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + BW'(1);
          if (clr_addr_r == BW'(csa_pkg::BODY_COUNT - 1)) begin
            state_r <= clr_rsp_r ? S_OUT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item_r <= in_data;
            sat_r  <= 1'b0;
            k_r    <= '0;
            ph_r   <= 1'b0;
            unique case (csa_pkg::op_t'(in_data.operation))
              csa_pkg::OP_CLEAR: begin
                res_r      <= '0;
                clr_rsp_r  <= 1'b1;
                clr_addr_r <= '0;
                state_r    <= S_CLEAR;
              end
              csa_pkg::OP_ACC: begin
                r_r <= r_pick;
                if (r_pick == 16'd0) begin
                  res_r   <= '{status: csa_pkg::ST_ZERO, default: '0};
                  state_r <= S_OUT;
                end else begin
                  res_r   <= '0;
                  state_r <= S_RR;
                end
              end
              csa_pkg::OP_READ: begin
                res_r   <= '0;
                state_r <= S_READ;
              end
              default: begin
                res_r   <= '0;
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_RR: begin
          ph_r <= !ph_r;
          if (ph_r) begin
            rr_r    <= prod[31:0];
            state_r <= S_AREA;
          end
        end
        S_AREA: begin
          ph_r <= !ph_r;
          if (ph_r) begin
            area_r  <= prod[49:16];
            dot_r   <= '0;
            k_r     <= '0;
            state_r <= S_DOT;
          end
        end
        S_DOT: begin
          ph_r <= !ph_r;
          if (ph_r) begin
            dot_r <= dot_r + prod[37:0];
            k_r   <= (k_r == 3'd2) ? 3'd0 : k_r + 3'd1;
            if (k_r == 3'd2) begin
              state_r <= S_ND;
            end
          end
        end
        S_ND: begin
          ph_r <= !ph_r;
          if (ph_r) begin
            nd_r[k_r[1:0]] <= {prod[55:0], 4'd0};
            k_r <= (k_r == 3'd2) ? 3'd0 : k_r + 3'd1;
            if (k_r == 3'd2) begin
              state_r <= S_SP;
            end
          end
        end
        S_SP: begin
          ph_r <= !ph_r;
          if (ph_r) begin
            sp_r[k_r[1:0]] <= prod[36:0];
            k_r <= (k_r == 3'd2) ? 3'd0 : k_r + 3'd1;
            if (k_r == 3'd2) begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (!ph_r) begin
            ph_r <= 1'b1;
          end else if (div_done) begin
            q_r[k_r] <= div_quo;
            ph_r     <= 1'b0;
            if (k_r == 3'd5) begin
              k_r     <= '0;
              state_r <= S_RMW;
            end else begin
              k_r <= k_r + 3'd1;
            end
          end
        end
        S_RMW: begin
          ph_r <= !ph_r;
          if (ph_r) begin
            // write back one body, then the other
            if (k_r[0]) begin
              res_r.status <= (sat_r || rmw_sat) ? csa_pkg::ST_SAT : csa_pkg::ST_OK;
              state_r      <= S_OUT;
            end else begin
              sat_r <= rmw_sat;
              k_r   <= 3'd1;
            end
          end
        end
        S_READ: begin
          ph_r <= !ph_r;
          if (ph_r) begin
            res_r.normal_stress_x <= rd_n[0][31:0];
            res_r.normal_stress_y <= rd_n[1][31:0];
            res_r.normal_stress_z <= rd_n[2][31:0];
            res_r.shear_stress_x  <= rd_s[0][31:0];
            res_r.shear_stress_y  <= rd_s[1][31:0];
            res_r.shear_stress_z  <= rd_s[2][31:0];
            res_r.status <= (rd_n[0][32] || rd_n[1][32] || rd_n[2][32] ||
                             rd_s[0][32] || rd_s[1][32] || rd_s[2][32]) ?
                            csa_pkg::ST_SAT : csa_pkg::ST_OK;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // hand the result to the output register once it is free
          if (!out_valid_r || !out_stall) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            clr_rsp_r   <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/csa_mul.sv =====
module csa_mul (
  input  logic                               clk,
  input  logic signed [csa_pkg::MUL_AW-1:0]  op_a,
  input  logic signed [csa_pkg::MUL_BW-1:0]  op_b,
  output logic signed [csa_pkg::MUL_PW-1:0]  prod_r
);

  // shared signed multiplier, product registered
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

// ===== rtl/csa_div.sv =====
module csa_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [csa_pkg::NUM_W-1:0]    num,
  input  logic [csa_pkg::AREA_W-1:0]          den,
  output logic                                done_r,
  output logic signed [csa_pkg::NUM_W-1:0]    quo
);

  logic                              busy_r;
  logic                              neg_r;
  logic [csa_pkg::NUM_W-1:0]         q_r;
  logic [csa_pkg::AREA_W:0]          rem_r;
  logic [csa_pkg::AREA_W-1:0]        den_r;
  logic [5:0]                        cnt_r;
  logic [csa_pkg::AREA_W+1:0]        trial;
  logic [csa_pkg::NUM_W-1:0]         mag;

  assign mag   = num[csa_pkg::NUM_W-1] ? csa_pkg::NUM_W'(-num) : csa_pkg::NUM_W'(num);
  assign trial = {1'b0, rem_r[csa_pkg::AREA_W-1:0], q_r[csa_pkg::NUM_W-1]} - {2'b00, den_r};
  assign quo   = neg_r ? -$signed(q_r) : $signed(q_r);

  // restoring division on magnitudes, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        neg_r  <= num[csa_pkg::NUM_W-1];
        q_r    <= mag;
        rem_r  <= '0;
        den_r  <= den;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (!trial[csa_pkg::AREA_W+1]) begin
          rem_r <= trial[csa_pkg::AREA_W:0];
          q_r   <= {q_r[csa_pkg::NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[csa_pkg::AREA_W-1:0], q_r[csa_pkg::NUM_W-1]};
          q_r   <= {q_r[csa_pkg::NUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(csa_pkg::NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== tb/tb_contact_stress_accumulator.sv =====
module tb_contact_stress_accumulator;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  csa_pkg::in_t   in_data;
  logic           out_valid;
  logic           out_stall;
  csa_pkg::out_t  out_data;

  contact_stress_accumulator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 3000;
  localparam int RANDOM_PER_PHASE = 345;

  typedef struct {
    csa_pkg::in_t  item;
    bit            typed;
    csa_pkg::out_t want;
  } row_t;

  // shadow copy of the per-body stress store
  longint shadow_normal [csa_pkg::BODY_COUNT][3];
  longint shadow_shear  [csa_pkg::BODY_COUNT][3];

  csa_pkg::out_t pending_stress_results [$];
  row_t          rows [$];
  int            fails;
  int            snd_idle_pct;
  int            rcv_idle_pct;
  bit            hold_go;
  bit            hold_done;
  int            hold_left;
  int            quiet_cycles;

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint sx(logic [63:0] v, int w);
    longint t;
    t = longint'(v << (64 - w));
    return t >>> (64 - w);
  endfunction

  function automatic longint clip(longint v, int w, inout bit sat);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic void add_to_body(int body, longint ns[3], longint ss[3], inout bit sat);
    if (body >= csa_pkg::BODY_COUNT) return;
    for (int k = 0; k < 3; k++) begin
      shadow_normal[body][k] = clip(shadow_normal[body][k] + ns[k], csa_pkg::STRESS_W, sat);
      shadow_shear[body][k]  = clip(shadow_shear[body][k] + ss[k], csa_pkg::STRESS_W, sat);
    end
  endfunction

  // stress result of one transaction, updating the shadow store
  function automatic csa_pkg::out_t stress_after_item(csa_pkg::in_t it);
    csa_pkg::out_t r;
    bit      sat;
    longint  rad;
    longint  area;
    longint  dot;
    longint  n[3];
    longint  f[3];
    longint  s[3];
    longint  ns[3];
    longint  ss[3];
    longint  rd[6];
    r   = '0;
    sat = 1'b0;
    case (csa_pkg::op_t'(it.operation))
      csa_pkg::OP_CLEAR: begin
        for (int b = 0; b < csa_pkg::BODY_COUNT; b++) begin
          for (int k = 0; k < 3; k++) begin
            shadow_normal[b][k] = 0;
            shadow_shear[b][k]  = 0;
          end
        end
      end
      csa_pkg::OP_READ: begin
        if (it.body_a < csa_pkg::BODY_COUNT) begin
          for (int k = 0; k < 3; k++) begin
            rd[k]     = clip(shadow_normal[it.body_a][k], 32, sat);
            rd[3 + k] = clip(shadow_shear[it.body_a][k], 32, sat);
          end
          r.normal_stress_x = rd[0][31:0];
          r.normal_stress_y = rd[1][31:0];
          r.normal_stress_z = rd[2][31:0];
          r.shear_stress_x  = rd[3][31:0];
          r.shear_stress_y  = rd[4][31:0];
          r.shear_stress_z  = rd[5][31:0];
          if (sat) r.status = csa_pkg::ST_SAT;
        end
      end
      csa_pkg::OP_ACC: begin
        // smaller nonzero radius
        if (it.radius_a == 0) rad = it.radius_b;
        else if (it.radius_b == 0) rad = it.radius_a;
        else rad = (it.radius_a < it.radius_b) ? it.radius_a : it.radius_b;
        area = (rad * rad * longint'(csa_pkg::PI_Q16)) >> 16;
        if (area == 0) begin
          r.status = csa_pkg::ST_ZERO;
        end else begin
          dot = 0;
          for (int k = 0; k < 3; k++) begin
            n[k] = sx(64'(it.normal_vec >> (16 * k)), 16);
            f[k] = sx(64'(it.normal_force_vec >> (20 * k)), 20);
            s[k] = sx(64'(it.shear_force_vec >> (20 * k)), 20);
            dot += n[k] * f[k];
          end
          for (int k = 0; k < 3; k++) begin
            ns[k] = (n[k] * dot * 16) / area;
            ss[k] = ((n[(k + 1) % 3] * s[(k + 1) % 3] + n[(k + 2) % 3] * s[(k + 2) % 3])
                     * 262144) / area;
          end
          add_to_body(it.body_a, ns, ss, sat);
          add_to_body(it.body_b, ns, ss, sat);
          if (sat) r.status = csa_pkg::ST_SAT;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [47:0] pack_n(int x, int y, int z);
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    a = x[15:0];
    b = y[15:0];
    c = z[15:0];
    return {c, b, a};
  endfunction

  function automatic logic [59:0] pack_f(int x, int y, int z);
    logic [19:0] a;
    logic [19:0] b;
    logic [19:0] c;
    a = x[19:0];
    b = y[19:0];
    c = z[19:0];
    return {c, b, a};
  endfunction

  function automatic csa_pkg::in_t mk(csa_pkg::op_t op, int a, int b, int ra, int rb,
                                      logic [47:0] nv, logic [59:0] fv, logic [59:0] sv);
    csa_pkg::in_t it;
    it.operation        = op;
    it.body_a           = a[9:0];
    it.body_b           = b[9:0];
    it.radius_a         = ra[15:0];
    it.radius_b         = rb[15:0];
    it.normal_vec       = nv;
    it.normal_force_vec = fv;
    it.shear_force_vec  = sv;
    return it;
  endfunction

  function automatic void add_row(csa_pkg::in_t it, bit typed, csa_pkg::out_t want);
    row_t r;
    r.item  = it;
    r.typed = typed;
    r.want  = want;
    rows.insert(rows.size(), r);
  endfunction

  function automatic int sgn_rand(int mag);
    return int'($urandom_range(2 * mag)) - mag;
  endfunction

  // random transaction, mostly contacts on a few bodies
  function automatic csa_pkg::in_t random_item();
    csa_pkg::in_t it;
    logic [255:0] raw;
    int           pick;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(csa_pkg::in_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 2) it.operation = csa_pkg::OP_CLEAR;
    else if (pick < 5) it.operation = csa_pkg::OP_NONE;
    else if (pick < 38) it.operation = csa_pkg::OP_READ;
    else it.operation = csa_pkg::OP_ACC;
    if ($urandom_range(99) < 80) begin
      it.body_a = 10'($urandom_range(15));
      it.body_b = 10'($urandom_range(15));
    end
    pick = $urandom_range(99);
    if (pick < 8) begin
      it.radius_a = '0;
      if ($urandom_range(1)) it.radius_b = '0;
    end else if (pick < 16) begin
      it.radius_b = '0;
    end else if (pick < 26) begin
      it.radius_a = 16'($urandom_range(1, 16));
    end else if (pick < 80) begin
      it.radius_a = 16'($urandom_range(128, 16384));
      it.radius_b = 16'($urandom_range(128, 16384));
    end
    if ($urandom_range(99) < 70)
      it.normal_vec = pack_n(sgn_rand(16384), sgn_rand(16384), sgn_rand(16384));
    if ($urandom_range(99) < 70)
      it.normal_force_vec = pack_f(sgn_rand(2000), sgn_rand(2000), sgn_rand(2000));
    if ($urandom_range(99) < 70)
      it.shear_force_vec = pack_f(sgn_rand(2000), sgn_rand(2000), sgn_rand(2000));
    return it;
  endfunction

  // offer one transaction and wait for it to be taken
  task automatic send(csa_pkg::in_t it, bit typed, csa_pkg::out_t want);
    csa_pkg::out_t got;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    got = stress_after_item(it);
    pending_stress_results.insert(pending_stress_results.size(), typed ? want : got);
  endtask

  task automatic chk(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  // receiver: random stall, long hold-off on request, result check
  always @(posedge clk) begin
    csa_pkg::out_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_stress_results.size() == 0) begin
          $error("unexpected result transaction");
          fails++;
        end else begin
          e = pending_stress_results.pop_front();
          chk("normal_stress_x", e.normal_stress_x, out_data.normal_stress_x);
          chk("normal_stress_y", e.normal_stress_y, out_data.normal_stress_y);
          chk("normal_stress_z", e.normal_stress_z, out_data.normal_stress_z);
          chk("shear_stress_x", e.shear_stress_x, out_data.shear_stress_x);
          chk("shear_stress_y", e.shear_stress_y, out_data.shear_stress_y);
          chk("shear_stress_z", e.shear_stress_z, out_data.shear_stress_z);
          chk("status", e.status, out_data.status);
        end
      end
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    csa_pkg::out_t zero_ok;
    csa_pkg::out_t zero_skip;
    hold_go      = 1'b0;
    snd_idle_pct = 34;
    rcv_idle_pct = 61;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    zero_ok      = '0;
    zero_skip    = '0;
    zero_skip.status = csa_pkg::ST_ZERO;

    // directed rows
    add_row(mk(csa_pkg::OP_READ, 0, 0, 0, 0, '0, '0, '0), 1, zero_ok);
    add_row(mk(csa_pkg::OP_READ, 1023, 0, 0, 0, '1, '1, '1), 1, zero_ok);
    add_row(mk(csa_pkg::OP_ACC, 3, 4, 0, 0, pack_n(16384, 0, 0), pack_f(100, 0, 0),
               pack_f(0, 5, 5)), 1, zero_skip);
    add_row(mk(csa_pkg::OP_READ, 3, 0, 0, 0, '0, '0, '0), 1, zero_ok);
    add_row(mk(csa_pkg::OP_NONE, 3, 4, 256, 256, pack_n(16384, 0, 0), pack_f(7, 0, 0), '0),
            1, zero_ok);
    add_row(mk(csa_pkg::OP_ACC, 3, 4, 256, 512, pack_n(16384, 0, 0), pack_f(1000, 0, 0),
               pack_f(0, 300, -300)), 0, zero_ok);
    add_row(mk(csa_pkg::OP_ACC, 3, 4, 0, 384, pack_n(0, -16384, 0), pack_f(0, 500, 9),
               pack_f(-77, 0, 12)), 0, zero_ok);
    add_row(mk(csa_pkg::OP_ACC, 4, 3, 640, 0, pack_n(11585, 0, -11585), pack_f(-40, 3, 60),
               pack_f(20, -20, 20)), 0, zero_ok);
    add_row(mk(csa_pkg::OP_READ, 3, 0, 0, 0, '0, '0, '0), 0, zero_ok);
    add_row(mk(csa_pkg::OP_READ, 4, 0, 0, 0, '0, '0, '0), 0, zero_ok);
    // same body twice, largest radius
    add_row(mk(csa_pkg::OP_ACC, 9, 9, 65535, 65535, pack_n(-32768, 32767, -32768),
               pack_f(-524288, 524287, -524288), pack_f(524287, -524288, 524287)),
            0, zero_ok);
    add_row(mk(csa_pkg::OP_READ, 9, 0, 0, 0, '0, '0, '0), 0, zero_ok);
    // tiny radius drives the accumulators into saturation both ways
    add_row(mk(csa_pkg::OP_ACC, 1023, 0, 1, 65535, pack_n(32767, 32767, 32767),
               pack_f(524287, 524287, 524287), pack_f(524287, 524287, 524287)),
            0, zero_ok);
    add_row(mk(csa_pkg::OP_ACC, 1023, 0, 1, 1, pack_n(32767, -32768, 32767),
               pack_f(-524288, 524287, -524288), pack_f(-524288, 524287, 524287)),
            0, zero_ok);
    add_row(mk(csa_pkg::OP_READ, 1023, 0, 0, 0, '0, '0, '0), 0, zero_ok);
    add_row(mk(csa_pkg::OP_READ, 0, 0, 0, 0, '0, '0, '0), 0, zero_ok);
    add_row(mk(csa_pkg::OP_CLEAR, 0, 0, 0, 0, '0, '0, '0), 1, zero_ok);
    add_row(mk(csa_pkg::OP_READ, 1023, 0, 0, 0, '0, '0, '0), 1, zero_ok);
    add_row(mk(csa_pkg::OP_READ, 9, 0, 0, 0, '0, '0, '0), 1, zero_ok);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].want);

    // random phases: sender busy, receiver busy, no idling with a long hold-off
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 61 : 0;
      rcv_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 34 : 0;
      if (ph == 2) hold_go = 1'b1;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send(random_item(), 0, zero_ok);
    end
    in_valid <= 1'b0;

    while (pending_stress_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
